// ===== rtl/bc_pkg.sv =====
package bc_pkg;

    localparam int COORD_W    = 8;
    localparam int FRAC_W     = 8;
    localparam int NUM_POINTS = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [FRAC_W-1:0] FRAC_MAX = 8'hFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_IS_CUBIC = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_ZERO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_ONE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_TWO      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POINT_THREE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_START_FRACTION = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRACTION_STEP  = 3'd6;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [FRAC_W-1:0]  frac_t;

    // One word moving down the row of interpolation cells.
    typedef struct packed {
        logic [NUM_POINTS-1:0][COORD_W-1:0] px;
        logic [NUM_POINTS-1:0][COORD_W-1:0] py;
        frac_t                              frac;
        logic                               cubic;
    } bc_word_t;

    // Interpolates from a toward b: a +/- ((|b - a| * (1 + t)) >> 8).
    function automatic coord_t lerp8(input coord_t a, input coord_t b, input frac_t t);
        coord_t      d;
        logic [16:0] prod;
        coord_t      s;
        d    = (b > a) ? (b - a) : (a - b);
        prod = 17'(d) * 17'({1'b0, t} + 9'd1);
        s    = prod[15:8];
        return (b > a) ? (a + s) : (a - s);
    endfunction

endpackage

// ===== rtl/bc_cell.sv =====
// One de Casteljau level: interpolates each pair of neighboring points and
// registers the result. In bypass the points pass through unchanged.
module bc_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             bypass,
    input  logic             in_valid,
    input  bc_pkg::bc_word_t in_word,
    output logic             out_valid,
    output bc_pkg::bc_word_t out_word
);

    logic             valid_reg;
    bc_pkg::bc_word_t word_reg;
    bc_pkg::bc_word_t word_next;

    // Interpolation between adjacent points, x and y lanes side by side.
    always_comb
    begin
        word_next = in_word;
        for (int k = 0; k < bc_pkg::NUM_POINTS - 1; k++)
        begin
            if (!bypass)
            begin
                word_next.px[k] = bc_pkg::lerp8(in_word.px[k], in_word.px[k+1], in_word.frac);
                word_next.py[k] = bc_pkg::lerp8(in_word.py[k], in_word.py[k+1], in_word.frac);
            end
        end
    end

    // Valid bit of this cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload register of this cell.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

// ===== rtl/bezier_curve_sampler.sv =====
// Bezier curve sampler: each input word yields one point of a quadratic or cubic
// curve at the current fraction (start fraction on restart), which then advances
// by the step and saturates at 255. Words are taken one per cycle while the
// output is free or being taken; each word goes through a row of three registered
// interpolation cells. The only loop is the fraction adder at the input.
// Configuration is written through cfg_we, cfg_index and cfg_data.
module bezier_curve_sampler (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bc_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [0] restart, [7:1] zero
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] sample_x, [15:8] sample_y, [23:16] used_fraction
    output logic [23:0]                    m_tdata,
    output logic                           m_tlast    // last
);

    logic                   cubic_reg;
    logic [15:0]            point_zero_reg;
    logic [15:0]            point_one_reg;
    logic [15:0]            point_two_reg;
    logic [15:0]            point_three_reg;
    bc_pkg::frac_t          start_reg;
    bc_pkg::frac_t          step_reg;
    bc_pkg::frac_t          fraction_reg;
    bc_pkg::frac_t          fraction_next;
    bc_pkg::frac_t          t_now;

    logic                   advance;
    logic                   accept;
    bc_pkg::bc_word_t       head_word;
    logic [2:0]             cell_valid;
    bc_pkg::bc_word_t [2:0] cell_word;

    // The whole row moves whenever the output register is free or being taken.
    assign advance  = !cell_valid[2] || m_tready;
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cubic_reg       <= 1'b0;
            point_zero_reg  <= '0;
            point_one_reg   <= '0;
            point_two_reg   <= '0;
            point_three_reg <= '0;
            start_reg       <= '0;
            step_reg        <= 8'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bc_pkg::REG_CURVE_IS_CUBIC: cubic_reg       <= cfg_data[0];
                bc_pkg::REG_POINT_ZERO:     point_zero_reg  <= cfg_data;
                bc_pkg::REG_POINT_ONE:      point_one_reg   <= cfg_data;
                bc_pkg::REG_POINT_TWO:      point_two_reg   <= cfg_data;
                bc_pkg::REG_POINT_THREE:    point_three_reg <= cfg_data;
                bc_pkg::REG_START_FRACTION: start_reg       <= cfg_data[7:0];
                bc_pkg::REG_FRACTION_STEP:  step_reg        <= cfg_data[7:0];
                default:                    ;
            endcase
        end
    end

    // Fraction used for this word and its saturating advance.
    always_comb
    begin
        t_now = s_tdata[0] ? start_reg : fraction_reg;
        if (t_now == bc_pkg::FRAC_MAX)
        begin
            fraction_next = bc_pkg::FRAC_MAX;
        end
        else if ((bc_pkg::FRAC_MAX - step_reg) > t_now)
        begin
            fraction_next = t_now + step_reg;
        end
        else
        begin
            fraction_next = bc_pkg::FRAC_MAX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fraction_reg <= '0;
        end
        else if (accept)
        begin
            fraction_reg <= fraction_next;
        end
    end

    // Word entering the first cell: control points split into x and y lanes.
    always_comb
    begin
        head_word.px[0] = point_zero_reg[7:0];
        head_word.px[1] = point_one_reg[7:0];
        head_word.px[2] = point_two_reg[7:0];
        head_word.px[3] = point_three_reg[7:0];
        head_word.py[0] = point_zero_reg[15:8];
        head_word.py[1] = point_one_reg[15:8];
        head_word.py[2] = point_two_reg[15:8];
        head_word.py[3] = point_three_reg[15:8];
        head_word.frac  = t_now;
        head_word.cubic = cubic_reg;
    end

    // Three de Casteljau levels; a quadratic curve skips the last one.
    bc_cell u_cell0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .bypass    (1'b0),
        .in_valid  (s_tvalid),
        .in_word   (head_word),
        .out_valid (cell_valid[0]),
        .out_word  (cell_word[0])
    );

    bc_cell u_cell1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .bypass    (1'b0),
        .in_valid  (cell_valid[0]),
        .in_word   (cell_word[0]),
        .out_valid (cell_valid[1]),
        .out_word  (cell_word[1])
    );

    bc_cell u_cell2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .bypass    (!cell_word[1].cubic),
        .in_valid  (cell_valid[1]),
        .in_word   (cell_word[1]),
        .out_valid (cell_valid[2]),
        .out_word  (cell_word[2])
    );

    // Output word from the last cell.
    assign m_tvalid = cell_valid[2];
    assign m_tdata  = {cell_word[2].frac, cell_word[2].py[0], cell_word[2].px[0]};
    assign m_tlast  = (cell_word[2].frac == bc_pkg::FRAC_MAX);

endmodule

// ===== rtl/bc_checker.sv =====
module bc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // The last flag marks exactly the samples taken at the curve end.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[23:16] == 8'hFF)))
        else $error("last flag does not match the used fraction");

    // A stalled output word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("stalled output word changed");

    // An empty output never blocks the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input blocked while output is empty");

    // The input is ready exactly when the output is free or being taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output state");

endmodule

bind bezier_curve_sampler bc_checker u_bc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
